// ----- rtl/slm_pkg.sv -----
package slm_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_CLEAR
  } state_t;

  // Request commands
  localparam logic [1:0] CMD_SHARED = 2'd0;
  localparam logic [1:0] CMD_EXCL   = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;

  // Verdict codes
  localparam logic [1:0] V_GRANTED = 2'd0;
  localparam logic [1:0] V_DENIED  = 2'd1;
  localparam logic [1:0] V_IGNORED = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic accept;       // request word taken this cycle
    logic commit;       // evaluate, write back, load result
    logic clear_start;  // restart clearing pass
    logic clear_step;   // zero one table entry and one ignored flag
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic is_end;       // request word on the input is end of case
    logic out_room;     // result register free or draining
    logic clear_last;   // clearing pass at its last entry
  } stat_t;

endpackage

// ----- rtl/slm_if.sv -----
// Request channel
interface slm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [5:0] txn_id;
  logic [7:0] item_id;

  modport source (output valid, cmd, txn_id, item_id, input ready);
  modport sink (input valid, cmd, txn_id, item_id, output ready);
endinterface

// Result channel
interface slm_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

// ----- rtl/slm_ram.sv -----
module slm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/slm_ctrl.sv -----
module slm_ctrl
  import slm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  state_t state, state_next;

  // State register; reset starts with a clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.is_end ? ST_CLEAR : ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.out_room) begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (stat.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready         = 1'b0;
    ctrl.accept      = 1'b0;
    ctrl.commit      = 1'b0;
    ctrl.clear_start = 1'b0;
    ctrl.clear_step  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready         = 1'b1;
        ctrl.accept      = in_valid;
        ctrl.clear_start = in_valid & stat.is_end;
      end
      ST_EVAL: begin
        ctrl.commit = stat.out_room;
      end
      ST_CLEAR: begin
        ctrl.clear_step = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/slm_dp.sv -----
module slm_dp
  import slm_pkg::*;
#(
  parameter int NUM_TXN   = 64,
  parameter int NUM_ITEMS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] cmd,
  input  logic [5:0] txn_id,
  input  logic [7:0] item_id,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] verdict,
  input  ctrl_t      ctrl,
  output stat_t      stat
);

  localparam int TXN_W  = (NUM_TXN > 1) ? $clog2(NUM_TXN) : 1;
  localparam int ITEM_W = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
  // entry: {owner txn, owner valid, shared holder bitmap}
  localparam int ENT_W  = NUM_TXN + 1 + TXN_W;
  // Clearing pass covers both the table and the ignored flags
  localparam int CLR_N  = (NUM_ITEMS > NUM_TXN) ? NUM_ITEMS : NUM_TXN;
  localparam int CLR_W  = $clog2(CLR_N);
  localparam logic [CLR_W:0] CLR_ITEM_END = (CLR_W+1)'(NUM_ITEMS);
  localparam logic [CLR_W:0] CLR_TXN_END  = (CLR_W+1)'(NUM_TXN);

  // Constant folding tables for out-of-range ids
  logic [TXN_W-1:0]  txn_map  [64];
  logic [ITEM_W-1:0] item_map [256];

  for (genvar g = 0; g < 64; g++) begin : g_txn_map
    assign txn_map[g] = TXN_W'(g % NUM_TXN);
  end
  for (genvar g = 0; g < 256; g++) begin : g_item_map
    assign item_map[g] = ITEM_W'(g % NUM_ITEMS);
  end

  // Latched request
  logic [1:0]        cmd_q;
  logic [TXN_W-1:0]  txn_q;
  logic [ITEM_W-1:0] item_q;

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_q  <= cmd;
      txn_q  <= txn_map[txn_id];
      item_q <= item_map[item_id];
    end
  end

  // Clearing pass counter
  logic [CLR_W-1:0] clr_cnt;
  logic             clr_item_ok;
  logic             clr_txn_ok;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_start) begin
      clr_cnt <= '0;
    end else if (ctrl.clear_step) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
    end
  end

  assign clr_item_ok = ({1'b0, clr_cnt} < CLR_ITEM_END);
  assign clr_txn_ok  = ({1'b0, clr_cnt} < CLR_TXN_END);

  // Lock table memory
  logic              ram_we;
  logic [ITEM_W-1:0] ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ITEM_W-1:0] ram_raddr;
  logic [ENT_W-1:0]  ram_rdata;

  slm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_ITEMS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Read on accept; hold the address afterwards so read data stays put
  assign ram_raddr = ctrl.accept ? item_map[item_id] : item_q;

  // Per-transaction ignored flags
  logic             flg_we;
  logic [TXN_W-1:0] flg_waddr;
  logic             flg_wdata;
  logic [TXN_W-1:0] flg_raddr;
  logic             flg_rdata;

  slm_ram #(
    .WIDTH (1),
    .DEPTH (NUM_TXN)
  ) u_flags (
    .clk   (clk),
    .we    (flg_we),
    .waddr (flg_waddr),
    .wdata (flg_wdata),
    .raddr (flg_raddr),
    .rdata (flg_rdata)
  );

  assign flg_raddr = ctrl.accept ? txn_map[txn_id] : txn_q;

  // Entry unpack
  logic [NUM_TXN-1:0] holders;
  logic               own_v;
  logic [TXN_W-1:0]   own_t;

  assign holders = ram_rdata[NUM_TXN-1:0];
  assign own_v   = ram_rdata[NUM_TXN];
  assign own_t   = ram_rdata[ENT_W-1 -: TXN_W];

  // Decision
  logic [NUM_TXN-1:0] me;
  logic               is_sh, is_ex, ignored, mine, granted;
  logic               has_result, do_write, set_ign;
  logic [1:0]         verdict_next;

  always_comb begin
    me      = NUM_TXN'(1) << txn_q;
    is_sh   = (cmd_q == CMD_SHARED);
    is_ex   = (cmd_q == CMD_EXCL);
    ignored = flg_rdata;
    mine    = own_v && (own_t == txn_q);
    if (is_sh) begin
      granted = !own_v || mine;
    end else if (holders != '0) begin
      granted = (holders == me);
    end else begin
      granted = !own_v || mine;
    end
    has_result = ignored || is_sh || is_ex;
    do_write   = !ignored && ((is_sh && !own_v) || (is_ex && granted));
    set_ign    = !ignored && (is_sh || is_ex) && !granted;
    if (ignored) begin
      verdict_next = V_IGNORED;
    end else if (granted) begin
      verdict_next = V_GRANTED;
    end else begin
      verdict_next = V_DENIED;
    end
  end

  // Write back or clear
  always_comb begin
    ram_we    = (ctrl.clear_step & clr_item_ok) | (ctrl.commit & do_write);
    ram_waddr = ctrl.clear_step ? ITEM_W'(clr_cnt) : item_q;
    if (ctrl.clear_step) begin
      ram_wdata = '0;
    end else begin
      ram_wdata = {(is_ex ? txn_q : own_t), (own_v | is_ex),
                   (holders | (is_sh ? me : '0))};
    end
  end

  // Ignored flags: set on denial, zeroed by the clearing pass
  always_comb begin
    flg_we    = (ctrl.clear_step & clr_txn_ok) | (ctrl.commit & set_ign);
    flg_waddr = ctrl.clear_step ? TXN_W'(clr_cnt) : txn_q;
    flg_wdata = !ctrl.clear_step;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.commit && has_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit && has_result) begin
      verdict <= verdict_next;
    end
  end

  // Status
  assign stat.is_end     = (cmd == CMD_END);
  assign stat.out_room   = !out_valid || out_ready;
  assign stat.clear_last = (clr_cnt == CLR_W'(CLR_N - 1));

endmodule

// ----- rtl/shared_exclusive_lock_manager_unit.sv -----
// Shared/exclusive lock table. Each request word names a command, a
// transaction and an item; shared and exclusive requests answer granted,
// denied or ignored, and a denial makes the transaction ignored until end of
// case. On accept a request reads the item's entry and the transaction's
// ignored flag from RAM; the evaluate state then checks and writes them back,
// and no new request is accepted before that. A result waiting in the output
// register is held while the next request is accepted; evaluation waits only
// if that register is still full. End of case and reset run a clearing pass
// over the table and the flags, one entry per cycle over NUM_ITEMS entries
// (or NUM_TXN if that is larger), during which no request is accepted.
module shared_exclusive_lock_manager_unit
  import slm_pkg::*;
#(
  parameter int NUM_TXN   = 64,
  parameter int NUM_ITEMS = 256
) (
  input logic  clk,
  input logic  rst,
  slm_req_if.sink   req,
  slm_rsp_if.source rsp
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequencer
  slm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // Table, flags and result register
  slm_dp #(
    .NUM_TXN   (NUM_TXN),
    .NUM_ITEMS (NUM_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (req.cmd),
    .txn_id    (req.txn_id),
    .item_id   (req.item_id),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .verdict   (rsp.verdict),
    .ctrl      (ctrl),
    .stat      (stat)
  );

endmodule
